FILE: src/wtrq_pkg.sv
package wtrq_pkg;

  // Queue depth and derived widths.
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths.
  localparam int TASK_W = 4;
  localparam int TIME_W = 63;
  localparam int STAT_W = 3;

  // Command kinds.
  localparam logic KIND_SCHED = 1'b0;
  localparam logic KIND_POP   = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_SCHEDULED = 3'd0;
  localparam logic [STAT_W-1:0] ST_DISPATCH  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_DUE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

endpackage

FILE: src/wake_time_ready_queue_unit.sv
// Pop: the word is latched, then S_POP compares the head and registers done with the result.
// Schedule: S_SCAN walks the queued entries, then S_REMOVE if the task is already queued,
// then S_INSERT, or a full queue drops it; one shared comparator scans a slot per cycle.
// busy is high from the accepted word until done; a new word may start while done shows.
// Synchronous active-high reset empties the queue; results are never stalled.
module wake_time_ready_queue_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [wtrq_pkg::TASK_W-1:0]  task_id,
  input  logic [wtrq_pkg::TIME_W-1:0]  event_time,
  output logic                         done,
  output logic [wtrq_pkg::STAT_W-1:0]  status,
  output logic [wtrq_pkg::TASK_W-1:0]  out_task,
  output logic [wtrq_pkg::TIME_W-1:0]  next_time
);
  import wtrq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_INSERT,
    S_POP
  } state_t;

  state_t state;

  // Queue slots, ascending wake time from slot 0; count entries are valid.
  logic [TASK_W-1:0] slot_task [MAX_TASKS];
  logic [TIME_W-1:0] slot_time [MAX_TASKS];
  logic [CNT_W-1:0]  count;

  // Latched request and scan bookkeeping.
  logic [TASK_W-1:0] req_task;
  logic [TIME_W-1:0] req_time;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rpos;
  logic [CNT_W-1:0]  lt_cnt;
  logic              found;
  logic              match_lt;

  // Shared compare unit on the slot picked by the scan index.
  logic [TIME_W-1:0] sel_time;
  logic              key_gt;
  logic              key_eq;
  logic              hit;
  logic              last;
  logic              found_any;
  logic [CNT_W-1:0]  ins_pos;

  assign sel_time  = slot_time[idx];
  assign key_gt    = req_time > sel_time;
  assign key_eq    = req_time == sel_time;
  assign hit       = slot_task[idx] == req_task;
  assign last      = {{(CNT_W-IDX_W){1'b0}}, idx} == (count - CNT_W'(1));
  assign found_any = found | hit;
  // Insert position in the queue once the old entry for this id is gone.
  assign ins_pos   = lt_cnt - CNT_W'(match_lt);

  // Sequencer, queue storage and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy     <= 1'b1;
            req_task <= task_id;
            req_time <= event_time;
            idx      <= '0;
            lt_cnt   <= '0;
            found    <= 1'b0;
            match_lt <= 1'b0;
            if (kind == KIND_POP) begin
              state <= S_POP;
            end else if (count == '0) begin
              state <= S_INSERT;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // One slot per cycle: look for the id and count earlier wake times.
          lt_cnt <= lt_cnt + CNT_W'(key_gt);
          if (hit) begin
            found    <= 1'b1;
            rpos     <= idx;
            match_lt <= key_gt;
          end
          idx <= idx + IDX_W'(1);
          if (last) begin
            if (!found_any && count == CNT_W'(MAX_TASKS)) begin
              done     <= 1'b1;
              busy     <= 1'b0;
              status   <= ST_FULL;
              out_task <= '0;
              next_time <= '0;
              state    <= S_IDLE;
            end else if (found_any) begin
              state <= S_REMOVE;
            end else begin
              state <= S_INSERT;
            end
          end
        end

        S_REMOVE: begin
          // Close the gap left by the old entry for this id.
          for (int i = 0; i < MAX_TASKS - 1; i++) begin
            if (IDX_W'(i) >= rpos) begin
              slot_task[i] <= slot_task[i+1];
              slot_time[i] <= slot_time[i+1];
            end
          end
          count <= count - CNT_W'(1);
          state <= S_INSERT;
        end

        S_INSERT: begin
          // Open a gap at the insert position and place the new entry there.
          for (int i = 1; i < MAX_TASKS; i++) begin
            if (CNT_W'(i) > ins_pos) begin
              slot_task[i] <= slot_task[i-1];
              slot_time[i] <= slot_time[i-1];
            end
          end
          slot_task[ins_pos[IDX_W-1:0]] <= req_task;
          slot_time[ins_pos[IDX_W-1:0]] <= req_time;
          count     <= count + CNT_W'(1);
          done      <= 1'b1;
          busy      <= 1'b0;
          status    <= ST_SCHEDULED;
          out_task  <= '0;
          next_time <= '0;
          state     <= S_IDLE;
        end

        S_POP: begin
          // The scan index is zero here, so the compare unit sees the head.
          done      <= 1'b1;
          busy      <= 1'b0;
          out_task  <= '0;
          next_time <= '0;
          state     <= S_IDLE;
          if (count == '0) begin
            status <= ST_EMPTY;
          end else if (!(key_gt || key_eq)) begin
            status    <= ST_NOT_DUE;
            next_time <= sel_time;
          end else begin
            status   <= ST_DISPATCH;
            out_task <= slot_task[0];
            for (int i = 0; i < MAX_TASKS - 1; i++) begin
              slot_task[i] <= slot_task[i+1];
              slot_time[i] <= slot_time[i+1];
            end
            count <= count - CNT_W'(1);
          end
        end

        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("queue count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && state == S_IDLE))
    else $error("result shown while still busy");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CNT_W'(MAX_TASKS)))
    else $error("full drop while queue not full");

  a_dispatch_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DISPATCH) |-> (count == $past(count) - CNT_W'(1)))
    else $error("dispatch did not shrink the queue");
`endif

endmodule
